// File: hdl/rkn_pkg.sv
// rkn_pkg: shared types, constants, saturating helpers and microprogram of the rkn integrator
package rkn_pkg;

	// number format and field widths
	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 24;
	localparam int PROD_BITS = 2 * WORD_BITS;
	localparam int H_BITS    = 31;
	localparam int POS_BITS  = 48;
	localparam int CNT_BITS  = 20;
	localparam int PC_BITS   = 6;
	localparam int IDX_BITS  = 3;
	localparam int IN_BITS   = 8;
	localparam int OUT_RAW   = 2 * WORD_BITS + POS_BITS + CNT_BITS;
	localparam int OUT_BITS  = ((OUT_RAW + 7) / 8) * 8;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic [WORD_BITS-1:0]        mag_t;
	typedef logic [PROD_BITS-1:0]        prod_t;

	localparam word_t W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam word_t W_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

	// unsigned divide by six: (n * ceil(2^34 / 6)) >> 34, exact for 32-bit n
	localparam mag_t DIV6_RECIP = 32'hAAAA_AAAB;
	localparam int   DIV6_SHIFT = 34;

	// configuration register indexes
	localparam logic [IDX_BITS-1:0] REG_STIFFNESS     = 3'd0;
	localparam logic [IDX_BITS-1:0] REG_STEP_SIZE     = 3'd1;
	localparam logic [IDX_BITS-1:0] REG_INITIAL_VALUE = 3'd2;
	localparam logic [IDX_BITS-1:0] REG_INITIAL_SLOPE = 3'd3;
	localparam logic [IDX_BITS-1:0] REG_STEPS_TOTAL   = 3'd4;

	// reset values
	localparam word_t               RST_STIFFNESS     = word_t'(32'sd16777216);
	localparam logic [H_BITS-1:0]   RST_STEP_SIZE     = 31'd16777;
	localparam word_t               RST_INITIAL_VALUE = '0;
	localparam word_t               RST_INITIAL_SLOPE = word_t'(32'sd16777216);
	localparam logic [CNT_BITS-1:0] RST_STEPS_TOTAL   = 20'd100000;
	localparam word_t               RST_SLOPE         = word_t'(32'sd16777216);

	// micro-operations
	typedef enum logic [3:0] {
		OP_SKIP,   // restart load, jump to emit unless advancing
		OP_MUL,    // product register <= |a| * |b|
		OP_MULD6,  // product register <= |a| * reciprocal of six
		OP_MRES,   // m <= signed product, scaled and saturated, or signed quotient by six
		OP_ADD,    // dst <= sat(a + b)
		OP_ADDHB,  // dst <= sat(a + b/2)
		OP_ADDHR,  // dst <= sat(a + b) / 2
		OP_NEG,    // dst <= sat(-a)
		OP_EMIT    // update position and count, load output register
	} op_t;

	typedef enum logic [3:0] {
		SRC_ZERO, SRC_Y, SRC_S, SRC_K, SRC_H, SRC_KK,
		SRC_D, SRC_P, SRC_WK, SRC_WD, SRC_T, SRC_M
	} src_t;

	typedef enum logic [3:0] {
		DST_NONE, DST_Y, DST_S, DST_KK, DST_D, DST_P, DST_WK, DST_WD, DST_T
	} dst_t;

	typedef struct packed {
		op_t                op;
		dst_t               dst;
		src_t               src_a;
		src_t               src_b;
		logic [PC_BITS-1:0] target;
	} uword_t;

	localparam logic [PC_BITS-1:0] PC_EMIT = 6'd59;

	// saturating add
	function automatic word_t sadd(input word_t a, input word_t b);
		logic signed [WORD_BITS:0] s;
		s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
		if (s[WORD_BITS] != s[WORD_BITS-1]) begin
			return s[WORD_BITS] ? W_MIN : W_MAX;
		end
		return word_t'(s[WORD_BITS-1:0]);
	endfunction

	// halve, truncating toward zero
	function automatic word_t shalf(input word_t a);
		word_t t;
		t = a + word_t'({{(WORD_BITS-1){1'b0}}, a[WORD_BITS-1]});
		return t >>> 1;
	endfunction

	// saturating negate
	function automatic word_t sneg(input word_t a);
		if (a == W_MIN) begin
			return W_MAX;
		end
		return -a;
	endfunction

	function automatic uword_t uw(input op_t op, input dst_t dst, input src_t a, input src_t b);
		uword_t w;
		w.op     = op;
		w.dst    = dst;
		w.src_a  = a;
		w.src_b  = b;
		w.target = PC_EMIT;
		return w;
	endfunction

	// microprogram for one integration step
	function automatic uword_t ucode(input logic [PC_BITS-1:0] pc);
		uword_t w;
		unique case (pc)
			6'd0:  w = uw(OP_SKIP,  DST_NONE, SRC_ZERO, SRC_ZERO);
			// stage 1
			6'd1:  w = uw(OP_MUL,   DST_NONE, SRC_K,    SRC_Y);
			6'd2:  w = uw(OP_MRES,  DST_NONE, SRC_ZERO, SRC_ZERO);
			6'd3:  w = uw(OP_NEG,   DST_KK,   SRC_M,    SRC_ZERO);
			6'd4:  w = uw(OP_ADD,   DST_WK,   SRC_ZERO, SRC_KK);
			6'd5:  w = uw(OP_MUL,   DST_NONE, SRC_KK,   SRC_H);
			6'd6:  w = uw(OP_MRES,  DST_NONE, SRC_ZERO, SRC_ZERO);
			6'd7:  w = uw(OP_ADDHB, DST_D,    SRC_S,    SRC_M);
			6'd8:  w = uw(OP_ADD,   DST_WD,   SRC_ZERO, SRC_D);
			6'd9:  w = uw(OP_ADDHR, DST_T,    SRC_S,    SRC_D);
			6'd10: w = uw(OP_MUL,   DST_NONE, SRC_H,    SRC_T);
			6'd11: w = uw(OP_MRES,  DST_NONE, SRC_ZERO, SRC_ZERO);
			6'd12: w = uw(OP_ADDHB, DST_P,    SRC_Y,    SRC_M);
			// stage 2
			6'd13: w = uw(OP_MUL,   DST_NONE, SRC_K,    SRC_P);
			6'd14: w = uw(OP_MRES,  DST_NONE, SRC_ZERO, SRC_ZERO);
			6'd15: w = uw(OP_NEG,   DST_KK,   SRC_M,    SRC_ZERO);
			6'd16: w = uw(OP_ADD,   DST_T,    SRC_KK,   SRC_KK);
			6'd17: w = uw(OP_ADD,   DST_WK,   SRC_WK,   SRC_T);
			6'd18: w = uw(OP_MUL,   DST_NONE, SRC_KK,   SRC_H);
			6'd19: w = uw(OP_MRES,  DST_NONE, SRC_ZERO, SRC_ZERO);
			6'd20: w = uw(OP_ADDHB, DST_D,    SRC_S,    SRC_M);
			6'd21: w = uw(OP_ADD,   DST_T,    SRC_D,    SRC_D);
			6'd22: w = uw(OP_ADD,   DST_WD,   SRC_WD,   SRC_T);
			6'd23: w = uw(OP_ADDHR, DST_T,    SRC_S,    SRC_D);
			6'd24: w = uw(OP_MUL,   DST_NONE, SRC_H,    SRC_T);
			6'd25: w = uw(OP_MRES,  DST_NONE, SRC_ZERO, SRC_ZERO);
			6'd26: w = uw(OP_ADDHB, DST_P,    SRC_Y,    SRC_M);
			// stage 3
			6'd27: w = uw(OP_MUL,   DST_NONE, SRC_K,    SRC_P);
			6'd28: w = uw(OP_MRES,  DST_NONE, SRC_ZERO, SRC_ZERO);
			6'd29: w = uw(OP_NEG,   DST_KK,   SRC_M,    SRC_ZERO);
			6'd30: w = uw(OP_ADD,   DST_T,    SRC_KK,   SRC_KK);
			6'd31: w = uw(OP_ADD,   DST_WK,   SRC_WK,   SRC_T);
			6'd32: w = uw(OP_MUL,   DST_NONE, SRC_KK,   SRC_H);
			6'd33: w = uw(OP_MRES,  DST_NONE, SRC_ZERO, SRC_ZERO);
			6'd34: w = uw(OP_ADD,   DST_D,    SRC_S,    SRC_M);
			6'd35: w = uw(OP_ADD,   DST_T,    SRC_D,    SRC_D);
			6'd36: w = uw(OP_ADD,   DST_WD,   SRC_WD,   SRC_T);
			6'd37: w = uw(OP_ADDHR, DST_T,    SRC_S,    SRC_D);
			6'd38: w = uw(OP_MUL,   DST_NONE, SRC_H,    SRC_T);
			6'd39: w = uw(OP_MRES,  DST_NONE, SRC_ZERO, SRC_ZERO);
			6'd40: w = uw(OP_ADD,   DST_P,    SRC_Y,    SRC_M);
			// stage 4
			6'd41: w = uw(OP_MUL,   DST_NONE, SRC_K,    SRC_P);
			6'd42: w = uw(OP_MRES,  DST_NONE, SRC_ZERO, SRC_ZERO);
			6'd43: w = uw(OP_NEG,   DST_KK,   SRC_M,    SRC_ZERO);
			6'd44: w = uw(OP_ADD,   DST_WK,   SRC_WK,   SRC_KK);
			6'd45: w = uw(OP_MUL,   DST_NONE, SRC_KK,   SRC_H);
			6'd46: w = uw(OP_MRES,  DST_NONE, SRC_ZERO, SRC_ZERO);
			6'd47: w = uw(OP_ADD,   DST_D,    SRC_S,    SRC_M);
			6'd48: w = uw(OP_ADD,   DST_WD,   SRC_WD,   SRC_D);
			// slope update
			6'd49: w = uw(OP_MUL,   DST_NONE, SRC_H,    SRC_WK);
			6'd50: w = uw(OP_MRES,  DST_NONE, SRC_ZERO, SRC_ZERO);
			6'd51: w = uw(OP_MULD6, DST_NONE, SRC_M,    SRC_ZERO);
			6'd52: w = uw(OP_MRES,  DST_NONE, SRC_ZERO, SRC_ZERO);
			6'd53: w = uw(OP_ADD,   DST_S,    SRC_S,    SRC_M);
			// value update
			6'd54: w = uw(OP_MUL,   DST_NONE, SRC_H,    SRC_WD);
			6'd55: w = uw(OP_MRES,  DST_NONE, SRC_ZERO, SRC_ZERO);
			6'd56: w = uw(OP_MULD6, DST_NONE, SRC_M,    SRC_ZERO);
			6'd57: w = uw(OP_MRES,  DST_NONE, SRC_ZERO, SRC_ZERO);
			6'd58: w = uw(OP_ADD,   DST_Y,    SRC_Y,    SRC_M);
			default: w = uw(OP_EMIT, DST_NONE, SRC_ZERO, SRC_ZERO);
		endcase
		return w;
	endfunction

endpackage

// File: hdl/rkn_oscillator_integrator.sv
// rkn_oscillator_integrator: microcoded fixed-step Runge-Kutta-Nystrom integrator for y'' = -k*y
//
// Each input beat either restarts the solution (restart = 1) or advances it by one step
// of size h, and each gives exactly one output beat with value and slope in Q8.24, position
// in unsigned Q24.24 and an integer step index; tlast is high once step_index >= steps_total.
// An advancing step runs a 60-word microprogram on one shared 32x32 multiplier with a
// product register and a saturating adder.
// A restart, or an advance once the step count is reached, jumps straight to the emit
// word. The next input beat is taken the cycle after the result is loaded into the
// output register, even while that result still waits for m_tready.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must write it only
// while the block is idle (the block does not enforce this); writes to unknown indexes are ignored.
module rkn_oscillator_integrator (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write port
	input  logic                             cfg_we,
	input  logic [rkn_pkg::IDX_BITS-1:0]     cfg_index,
	input  logic [rkn_pkg::WORD_BITS-1:0]    cfg_data,
	// input stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [rkn_pkg::IN_BITS-1:0]      s_tdata,   // [0] restart, rest zero
	// output stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [rkn_pkg::OUT_BITS-1:0]     m_tdata,   // value, slope, position, step_index
	output logic                             m_tlast
);

	// configuration registers
	rkn_pkg::word_t                   stiff_q;
	logic [rkn_pkg::H_BITS-1:0]       h_q;
	rkn_pkg::word_t                   init_value_q;
	rkn_pkg::word_t                   init_slope_q;
	logic [rkn_pkg::CNT_BITS-1:0]     total_q;

	// solution state
	rkn_pkg::word_t                   y_q;
	rkn_pkg::word_t                   s_q;
	logic [rkn_pkg::POS_BITS-1:0]     pos_q;
	logic [rkn_pkg::CNT_BITS-1:0]     cnt_q;

	// sequencer
	logic                             busy_q;
	logic [rkn_pkg::PC_BITS-1:0]      pc_q;
	logic                             restart_q;
	logic                             adv_q;
	rkn_pkg::uword_t                  uw;

	// datapath scratch registers
	rkn_pkg::word_t                   kk_q, d_q, p_q, wk_q, wd_q, t_q, m_q;
	rkn_pkg::prod_t                   prod_q;
	logic                             neg_q;
	logic                             div6_q;

	// output register
	logic                             m_tvalid_q;
	logic [rkn_pkg::OUT_BITS-1:0]     m_tdata_q;
	logic                             m_tlast_q;

	rkn_pkg::word_t                   opa, opb, alu_res, mres, h_word;
	rkn_pkg::mag_t                    mag_a, mag_b;
	logic                             accept, out_free, emit_fire, wb_en;
	logic [rkn_pkg::POS_BITS-1:0]     pos_nxt;
	logic [rkn_pkg::CNT_BITS-1:0]     cnt_nxt;
	logic [rkn_pkg::PROD_BITS-1-rkn_pkg::FRAC_BITS:0] q_s;
	logic [rkn_pkg::PROD_BITS-1-rkn_pkg::FRAC_BITS:0] lim_s;
	logic [rkn_pkg::PROD_BITS-1-rkn_pkg::FRAC_BITS:0] qc_s;
	logic [rkn_pkg::PROD_BITS-1-rkn_pkg::DIV6_SHIFT:0] q_6;

	assign uw        = rkn_pkg::ucode(pc_q);
	assign accept    = s_tvalid && s_tready;
	assign s_tready  = !busy_q;
	assign out_free  = !m_tvalid_q || m_tready;
	assign emit_fire = busy_q && (uw.op == rkn_pkg::OP_EMIT) && out_free;
	assign h_word    = rkn_pkg::word_t'({1'b0, h_q});

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiff_q      <= rkn_pkg::RST_STIFFNESS;
			h_q          <= rkn_pkg::RST_STEP_SIZE;
			init_value_q <= rkn_pkg::RST_INITIAL_VALUE;
			init_slope_q <= rkn_pkg::RST_INITIAL_SLOPE;
			total_q      <= rkn_pkg::RST_STEPS_TOTAL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rkn_pkg::REG_STIFFNESS:     stiff_q      <= cfg_data;
				rkn_pkg::REG_STEP_SIZE:     h_q          <= cfg_data[rkn_pkg::H_BITS-1:0];
				rkn_pkg::REG_INITIAL_VALUE: init_value_q <= cfg_data;
				rkn_pkg::REG_INITIAL_SLOPE: init_slope_q <= cfg_data;
				rkn_pkg::REG_STEPS_TOTAL:   total_q      <= cfg_data[rkn_pkg::CNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// operand selection
	always_comb begin
		unique case (uw.src_a)
			rkn_pkg::SRC_Y:  opa = y_q;
			rkn_pkg::SRC_S:  opa = s_q;
			rkn_pkg::SRC_K:  opa = stiff_q;
			rkn_pkg::SRC_H:  opa = h_word;
			rkn_pkg::SRC_KK: opa = kk_q;
			rkn_pkg::SRC_D:  opa = d_q;
			rkn_pkg::SRC_P:  opa = p_q;
			rkn_pkg::SRC_WK: opa = wk_q;
			rkn_pkg::SRC_WD: opa = wd_q;
			rkn_pkg::SRC_T:  opa = t_q;
			rkn_pkg::SRC_M:  opa = m_q;
			default:         opa = '0;
		endcase
		unique case (uw.src_b)
			rkn_pkg::SRC_Y:  opb = y_q;
			rkn_pkg::SRC_S:  opb = s_q;
			rkn_pkg::SRC_K:  opb = stiff_q;
			rkn_pkg::SRC_H:  opb = h_word;
			rkn_pkg::SRC_KK: opb = kk_q;
			rkn_pkg::SRC_D:  opb = d_q;
			rkn_pkg::SRC_P:  opb = p_q;
			rkn_pkg::SRC_WK: opb = wk_q;
			rkn_pkg::SRC_WD: opb = wd_q;
			rkn_pkg::SRC_T:  opb = t_q;
			rkn_pkg::SRC_M:  opb = m_q;
			default:         opb = '0;
		endcase
	end

	// multiplier operands as magnitudes, sign kept apart
	always_comb begin
		mag_a = opa[rkn_pkg::WORD_BITS-1] ? rkn_pkg::mag_t'(-opa) : rkn_pkg::mag_t'(opa);
		if (uw.op == rkn_pkg::OP_MULD6) begin
			mag_b = rkn_pkg::DIV6_RECIP;
		end else begin
			mag_b = opb[rkn_pkg::WORD_BITS-1] ? rkn_pkg::mag_t'(-opb) : rkn_pkg::mag_t'(opb);
		end
	end

	// product scaling with truncation and saturation, or the quotient by six
	always_comb begin
		q_s   = prod_q[rkn_pkg::PROD_BITS-1:rkn_pkg::FRAC_BITS];
		lim_s = neg_q ? ($bits(lim_s))'(rkn_pkg::mag_t'(rkn_pkg::W_MIN))
		              : ($bits(lim_s))'(rkn_pkg::mag_t'(rkn_pkg::W_MAX));
		qc_s  = (q_s > lim_s) ? lim_s : q_s;
		q_6   = prod_q[rkn_pkg::PROD_BITS-1:rkn_pkg::DIV6_SHIFT];
		if (div6_q) begin
			mres = neg_q ? -rkn_pkg::word_t'(q_6) : rkn_pkg::word_t'(q_6);
		end else begin
			mres = neg_q ? -rkn_pkg::word_t'(qc_s[rkn_pkg::WORD_BITS-1:0])
			             : rkn_pkg::word_t'(qc_s[rkn_pkg::WORD_BITS-1:0]);
		end
	end

	// saturating adder
	always_comb begin
		wb_en = 1'b0;
		case (uw.op)
			rkn_pkg::OP_ADD: begin
				alu_res = rkn_pkg::sadd(opa, opb);
				wb_en   = busy_q;
			end
			rkn_pkg::OP_ADDHB: begin
				alu_res = rkn_pkg::sadd(opa, rkn_pkg::shalf(opb));
				wb_en   = busy_q;
			end
			rkn_pkg::OP_ADDHR: begin
				alu_res = rkn_pkg::shalf(rkn_pkg::sadd(opa, opb));
				wb_en   = busy_q;
			end
			rkn_pkg::OP_NEG: begin
				alu_res = rkn_pkg::sneg(opa);
				wb_en   = busy_q;
			end
			default: alu_res = opa;
		endcase
	end

	// position and count after this item
	always_comb begin
		if (restart_q) begin
			pos_nxt = '0;
			cnt_nxt = '0;
		end else if (adv_q) begin
			pos_nxt = pos_q + rkn_pkg::POS_BITS'(h_q);
			cnt_nxt = cnt_q + rkn_pkg::CNT_BITS'(1);
		end else begin
			pos_nxt = pos_q;
			cnt_nxt = cnt_q;
		end
	end

	// program counter, jumps and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			pc_q       <= '0;
			restart_q  <= 1'b0;
			adv_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (emit_fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (accept) begin
				busy_q    <= 1'b1;
				pc_q      <= '0;
				restart_q <= s_tdata[0];
				adv_q     <= !s_tdata[0] && (cnt_q < total_q);
			end else if (busy_q) begin
				unique case (uw.op)
					rkn_pkg::OP_SKIP: pc_q <= adv_q ? pc_q + rkn_pkg::PC_BITS'(1) : uw.target;
					rkn_pkg::OP_EMIT: begin
						if (out_free) begin
							busy_q <= 1'b0;
						end
					end
					default: pc_q <= pc_q + rkn_pkg::PC_BITS'(1);
				endcase
			end
		end
	end

	// solution state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y_q   <= '0;
			s_q   <= rkn_pkg::RST_SLOPE;
			pos_q <= '0;
			cnt_q <= '0;
		end else begin
			if (busy_q && uw.op == rkn_pkg::OP_SKIP && restart_q) begin
				y_q <= init_value_q;
				s_q <= init_slope_q;
			end
			if (wb_en && uw.dst == rkn_pkg::DST_Y) begin
				y_q <= alu_res;
			end
			if (wb_en && uw.dst == rkn_pkg::DST_S) begin
				s_q <= alu_res;
			end
			if (emit_fire) begin
				pos_q <= pos_nxt;
				cnt_q <= cnt_nxt;
			end
		end
	end

	// scratch registers, multiplier and result register
	always_ff @(posedge clk) begin
		if (busy_q && (uw.op == rkn_pkg::OP_MUL || uw.op == rkn_pkg::OP_MULD6)) begin
			prod_q <= mag_a * mag_b;
			div6_q <= (uw.op == rkn_pkg::OP_MULD6);
			neg_q  <= (uw.op == rkn_pkg::OP_MULD6) ? opa[rkn_pkg::WORD_BITS-1]
			          : (opa[rkn_pkg::WORD_BITS-1] ^ opb[rkn_pkg::WORD_BITS-1]);
		end
		if (busy_q && uw.op == rkn_pkg::OP_MRES) begin
			m_q <= mres;
		end
		if (wb_en) begin
			unique case (uw.dst)
				rkn_pkg::DST_KK: kk_q <= alu_res;
				rkn_pkg::DST_D:  d_q  <= alu_res;
				rkn_pkg::DST_P:  p_q  <= alu_res;
				rkn_pkg::DST_WK: wk_q <= alu_res;
				rkn_pkg::DST_WD: wd_q <= alu_res;
				rkn_pkg::DST_T:  t_q  <= alu_res;
				default: ;
			endcase
		end
		if (emit_fire) begin
			m_tdata_q <= rkn_pkg::OUT_BITS'({cnt_nxt, pos_nxt, s_q, y_q});
			m_tlast_q <= (cnt_nxt >= total_q);
		end
	end

`ifndef ASSERT_OFF
	// an accepted beat starts the program at its first word
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy_q && pc_q == '0))
		else $error("sequencer did not start at word zero");

	// the program counter never runs past the emit word
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (pc_q <= rkn_pkg::PC_EMIT))
		else $error("program counter out of range");

	// the step count only moves when a result is emitted
	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!emit_fire |=> $stable(cnt_q))
		else $error("step count changed outside emit");

	// a restart emits point zero
	a_restart_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_fire && restart_q) |=>
		(m_tvalid && m_tdata[rkn_pkg::OUT_RAW-1 -: rkn_pkg::CNT_BITS] == '0))
		else $error("restart did not emit step index zero");
`endif

endmodule
